FILE: hdl/smrs_pkg.sv
// Shared types and constants for the sparse register store.
`default_nettype none
package smrs_pkg;

	localparam int ADDR_W  = 32;
	localparam int DATA_W  = 16;
	localparam int BIT_W   = 4;
	localparam int CFG_W   = 32;
	localparam int CFG_AW  = 5;
	localparam int NUM_WIN = 4;

	typedef enum logic [1:0] {
		OP_RD_WORD = 2'd0,
		OP_WR_WORD = 2'd1,
		OP_RD_BIT  = 2'd2,
		OP_WR_BIT  = 2'd3
	} op_t;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_COIL_BASE     = 3'd0;
	localparam logic [2:0] REG_IN_COIL_BASE  = 3'd1;
	localparam logic [2:0] REG_IN_REG_BASE   = 3'd2;
	localparam logic [2:0] REG_HOLD_REG_BASE = 3'd3;
	localparam logic [2:0] REG_BIT_OFFSET    = 3'd4;

	localparam logic [CFG_W-1:0] RST_COIL_BASE     = 32'd0;
	localparam logic [CFG_W-1:0] RST_IN_COIL_BASE  = 32'd256;
	localparam logic [CFG_W-1:0] RST_IN_REG_BASE   = 32'd512;
	localparam logic [CFG_W-1:0] RST_HOLD_REG_BASE = 32'd768;
	localparam logic [CFG_W-1:0] RST_BIT_OFFSET    = 32'd0;

endpackage
`default_nettype wire

FILE: hdl/smrs_if.sv
// Request and response channel interfaces of the register store.
`default_nettype none
interface smrs_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [smrs_pkg::ADDR_W-1:0]   addr;
	logic [smrs_pkg::DATA_W-1:0]   write_data;
	logic                          bit_value;

	modport source (output valid, op, addr, write_data, bit_value, input ready);
	modport sink   (input valid, op, addr, write_data, bit_value, output ready);
endinterface

interface smrs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [smrs_pkg::DATA_W-1:0]   read_data;
	logic                          read_bit;
	logic                          status;

	modport source (output valid, read_data, read_bit, status, input ready);
	modport sink   (input valid, read_data, read_bit, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/sparse_modbus_register_store_top.sv
// Sparse register store top: four config windows in RAM plus a searched overflow table.
// Window hit: accept, then window match + RAM read, then modify/write and result.
// Overflow access: the allocated entries are scanned, one entry scanned per cycle. One item in
// flight: the request port is ready again in the same cycle that each result is posted.
// Reset: config regs take their defaults; the window RAM is then zeroed by a clearing pass
// over all 4*WINDOW_SIZE words during which no item is accepted (config writes still are).
`default_nettype none
module sparse_modbus_register_store_top #(
	parameter int WINDOW_SIZE      = 256,
	parameter int OVERFLOW_ENTRIES = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	smrs_req_if.sink                           req,
	smrs_rsp_if.source                         rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [smrs_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [smrs_pkg::CFG_W-1:0]    pwdata,
	output logic      [smrs_pkg::CFG_W-1:0]    prdata,
	output logic                               pready
);
	localparam int WIN_DEPTH = smrs_pkg::NUM_WIN * WINDOW_SIZE;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int OVF_AW    = OVERFLOW_ENTRIES > 1 ? $clog2(OVERFLOW_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(OVERFLOW_ENTRIES + 1);
	localparam int OVF_W     = smrs_pkg::ADDR_W + smrs_pkg::DATA_W;
	localparam int AW        = smrs_pkg::ADDR_W;
	localparam int DW        = smrs_pkg::DATA_W;

	// one-hot sequencer
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_LOOKUP = 5'b00100,
		ST_WDATA  = 5'b01000,
		ST_SEARCH = 5'b10000
	} state_t;

	// result of one read-modify-write on a register value
	typedef struct packed {
		logic [DW-1:0] new_val;
		logic [DW-1:0] rdata;
		logic          rbit;
	} mod_t;

	function automatic mod_t modify(
		input smrs_pkg::op_t         op,
		input logic [DW-1:0]         old,
		input logic [DW-1:0]         wdata,
		input logic                  bval,
		input logic [smrs_pkg::BIT_W-1:0] pos
	);
		mod_t          r;
		logic [DW-1:0] mask;
		mask      = DW'(1) << pos;
		r.new_val = old;
		r.rdata   = '0;
		r.rbit    = 1'b0;
		case (op)
			smrs_pkg::OP_RD_WORD: r.rdata = old;
			smrs_pkg::OP_WR_WORD: r.new_val = wdata;
			smrs_pkg::OP_RD_BIT:  r.rbit = old[pos];
			smrs_pkg::OP_WR_BIT:  r.new_val = bval ? (old | mask) : (old & ~mask);
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// Configuration registers (APB). Writes land on the access phase.
	// ---------------------------------------------------------------------------
	logic [smrs_pkg::CFG_W-1:0] base_q [smrs_pkg::NUM_WIN];
	logic [smrs_pkg::CFG_W-1:0] bit_off_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= smrs_pkg::RST_COIL_BASE;
			base_q[1] <= smrs_pkg::RST_IN_COIL_BASE;
			base_q[2] <= smrs_pkg::RST_IN_REG_BASE;
			base_q[3] <= smrs_pkg::RST_HOLD_REG_BASE;
			bit_off_q <= smrs_pkg::RST_BIT_OFFSET;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				smrs_pkg::REG_COIL_BASE:     base_q[0] <= pwdata;
				smrs_pkg::REG_IN_COIL_BASE:  base_q[1] <= pwdata;
				smrs_pkg::REG_IN_REG_BASE:   base_q[2] <= pwdata;
				smrs_pkg::REG_HOLD_REG_BASE: base_q[3] <= pwdata;
				smrs_pkg::REG_BIT_OFFSET:    bit_off_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			smrs_pkg::REG_COIL_BASE:     prdata = base_q[0];
			smrs_pkg::REG_IN_COIL_BASE:  prdata = base_q[1];
			smrs_pkg::REG_IN_REG_BASE:   prdata = base_q[2];
			smrs_pkg::REG_HOLD_REG_BASE: prdata = base_q[3];
			smrs_pkg::REG_BIT_OFFSET:    prdata = bit_off_q;
			default:                     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------
	// Item registers and sequencer state
	// ---------------------------------------------------------------------------
	state_t                     state_q;
	logic [WIN_AW-1:0]          clr_q;       // clearing pass pointer
	smrs_pkg::op_t              op_q;
	logic [AW-1:0]              tgt_q;       // resolved register address
	logic [DW-1:0]              wdata_q;
	logic                       bval_q;
	logic [smrs_pkg::BIT_W-1:0] bitpos_q;
	logic [WIN_AW-1:0]          win_idx_q;
	logic [CNT_W-1:0]           cnt_q;       // allocated overflow entries
	logic [CNT_W-1:0]           rd_idx_q;    // next overflow entry to read
	logic [OVF_AW-1:0]          cmp_idx_s1;  // entry now on the RAM output
	logic                       cmp_vld_s1;
	logic                       out_valid_q;
	logic [DW-1:0]              out_rdata_q;
	logic                       out_rbit_q;
	logic                       out_status_q;

	// RAM ports
	logic              win_we, win_re;
	logic [WIN_AW-1:0] win_wa, win_ra;
	logic [DW-1:0]     win_wd, win_rd;
	logic              ovf_we, ovf_re;
	logic [OVF_AW-1:0] ovf_wa, ovf_ra;
	logic [OVF_W-1:0]  ovf_wd, ovf_rd;

	smrs_ram #(.WIDTH(DW), .DEPTH(WIN_DEPTH)) u_win_ram (
		.clk     (clk),
		.wr_en   (win_we),
		.wr_addr (win_wa),
		.wr_data (win_wd),
		.rd_en   (win_re),
		.rd_addr (win_ra),
		.rd_data (win_rd)
	);

	// overflow entry = {address, data}
	smrs_ram #(.WIDTH(OVF_W), .DEPTH(OVERFLOW_ENTRIES)) u_ovf_ram (
		.clk     (clk),
		.wr_en   (ovf_we),
		.wr_addr (ovf_wa),
		.wr_data (ovf_wd),
		.rd_en   (ovf_re),
		.rd_addr (ovf_ra),
		.rd_data (ovf_rd)
	);

	// ---------------------------------------------------------------------------
	// Window match: highest matching window wins, no wrap past the top of memory.
	// ---------------------------------------------------------------------------
	logic              win_hit;
	logic [WIN_AW-1:0] win_idx;

	always_comb begin
		logic [AW-1:0] diff;
		win_hit = 1'b0;
		win_idx = '0;
		for (int w = 0; w < smrs_pkg::NUM_WIN; w++) begin
			diff = tgt_q - base_q[w];
			if (tgt_q >= base_q[w] && diff < AW'(WINDOW_SIZE)) begin
				win_hit = 1'b1;
				win_idx = WIN_AW'(w * WINDOW_SIZE) + diff[WIN_AW-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Modify / complete
	// ---------------------------------------------------------------------------
	logic          fin_ok, ovf_hit, more, is_wr, full;
	logic          done, alloc, fail;
	logic [DW-1:0] old_val;
	mod_t          res;

	always_comb begin
		fin_ok  = !out_valid_q || rsp.ready;
		ovf_hit = cmp_vld_s1 && (ovf_rd[OVF_W-1:DW] == tgt_q);
		more    = rd_idx_q != cnt_q;
		is_wr   = (op_q == smrs_pkg::OP_WR_WORD) || (op_q == smrs_pkg::OP_WR_BIT);
		full    = cnt_q == CNT_W'(OVERFLOW_ENTRIES);

		if (state_q == ST_WDATA) begin
			old_val = win_rd;
		end else if (ovf_hit) begin
			old_val = ovf_rd[DW-1:0];
		end else begin
			old_val = '0;  // absent, or freshly allocated
		end
		res = modify(op_q, old_val, wdata_q, bval_q, bitpos_q);

		done  = (state_q == ST_WDATA && fin_ok)
		     || (state_q == ST_SEARCH && fin_ok && (ovf_hit || !more));
		alloc = state_q == ST_SEARCH && fin_ok && !ovf_hit && !more && is_wr && !full;
		fail  = state_q == ST_SEARCH && !ovf_hit && !more && is_wr && full;

		win_we = (state_q == ST_CLEAR) || (state_q == ST_WDATA && fin_ok && is_wr);
		win_wa = (state_q == ST_CLEAR) ? clr_q : win_idx_q;
		win_wd = (state_q == ST_CLEAR) ? '0 : res.new_val;
		win_re = state_q == ST_LOOKUP && win_hit;
		win_ra = win_idx;

		// scan holds while a hit waits for the output slot
		ovf_re = state_q == ST_SEARCH && !ovf_hit && more;
		ovf_ra = rd_idx_q[OVF_AW-1:0];
		ovf_we = (state_q == ST_SEARCH && fin_ok && ovf_hit && is_wr) || alloc;
		ovf_wa = ovf_hit ? cmp_idx_s1 : cnt_q[OVF_AW-1:0];
		ovf_wd = {tgt_q, res.new_val};
	end

	assign req.ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WIN_AW'(WIN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					rd_idx_q   <= '0;
					cmp_vld_s1 <= 1'b0;
					state_q    <= win_hit ? ST_WDATA : ST_SEARCH;
				end
				ST_WDATA: begin
					if (fin_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (ovf_re) begin
						rd_idx_q   <= rd_idx_q + 1'b1;
						cmp_vld_s1 <= 1'b1;
					end else if (!ovf_hit) begin
						cmp_vld_s1 <= 1'b0;
					end
					if (alloc) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q     <= smrs_pkg::op_t'(req.op);
			wdata_q  <= req.write_data;
			bval_q   <= req.bit_value;
			bitpos_q <= req.addr[smrs_pkg::BIT_W-1:0];
			if (req.op[1]) begin
				tgt_q <= (req.addr >> smrs_pkg::BIT_W) + bit_off_q;
			end else begin
				tgt_q <= req.addr;
			end
		end
		if (state_q == ST_LOOKUP) begin
			win_idx_q <= win_idx;
		end
		if (ovf_re) begin
			cmp_idx_s1 <= rd_idx_q[OVF_AW-1:0];
		end
		if (done) begin
			out_rdata_q  <= res.rdata;
			out_rbit_q   <= res.rbit;
			out_status_q <= fail;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_rdata_q;
	assign rsp.read_bit  = out_rbit_q;
	assign rsp.status    = out_status_q;

	// ---------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OVERFLOW_ENTRIES))
		else $error("overflow count beyond table size");

	a_hit_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && ovf_hit) |-> (CNT_W'(cmp_idx_s1) < cnt_q))
		else $error("overflow hit on unallocated entry");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == ST_IDLE && out_valid_q))
		else $error("completion did not post a result");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WDATA || state_q == ST_SEARCH))
		else $error("result posted outside an access");

endmodule
`default_nettype wire

FILE: hdl/smrs_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module smrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: test/tb_sparse_modbus_register_store_top.sv
// Self-checking testbench for the sparse register store: shadow model, APB setup, random traffic.
`default_nettype none

typedef struct packed {
	logic [smrs_pkg::DATA_W-1:0] read_data;
	logic                        read_bit;
	logic                        status;
} smrs_reply_t;

// Shadow copy of the register store; predicts one reply per accepted access.
class reg_store_shadow #(int WIN_SIZE = 256, int OVF_DEPTH = 64);
	logic [smrs_pkg::CFG_W-1:0]  win_base [smrs_pkg::NUM_WIN];
	logic [smrs_pkg::CFG_W-1:0]  bit_offset;
	logic [smrs_pkg::DATA_W-1:0] win_mem [smrs_pkg::NUM_WIN*WIN_SIZE];
	logic [smrs_pkg::ADDR_W-1:0] ovf_addr [OVF_DEPTH];
	logic [smrs_pkg::DATA_W-1:0] ovf_data [OVF_DEPTH];
	int                          ovf_used;
	smrs_reply_t                 pending_replies [$];
	int                          mismatches;

	function new();
		win_base[0] = smrs_pkg::RST_COIL_BASE;
		win_base[1] = smrs_pkg::RST_IN_COIL_BASE;
		win_base[2] = smrs_pkg::RST_IN_REG_BASE;
		win_base[3] = smrs_pkg::RST_HOLD_REG_BASE;
		bit_offset  = smrs_pkg::RST_BIT_OFFSET;
		foreach (win_mem[i]) win_mem[i] = '0;
		ovf_used   = 0;
		mismatches = 0;
	endfunction

	function void set_cfg(input logic [2:0] idx, input logic [smrs_pkg::CFG_W-1:0] val);
		if (idx == smrs_pkg::REG_BIT_OFFSET)
			bit_offset = val;
		else
			win_base[idx] = val;
	endfunction

	// Highest matching window wins; otherwise search the allocated table entries.
	function int find_reg(input logic [smrs_pkg::ADDR_W-1:0] a, output bit in_win);
		int slot;
		slot   = -1;
		in_win = 1'b0;
		for (int w = 0; w < smrs_pkg::NUM_WIN; w++) begin
			if (a >= win_base[w] && (a - win_base[w]) < 32'(WIN_SIZE)) begin
				in_win = 1'b1;
				slot   = w * WIN_SIZE + int'(a - win_base[w]);
			end
		end
		if (in_win)
			return slot;
		for (int i = 0; i < ovf_used; i++) begin
			if (ovf_addr[i] == a)
				return i;
		end
		return -1;
	endfunction

	function void apply_access(input smrs_pkg::op_t op, input logic [smrs_pkg::ADDR_W-1:0] a,
			input logic [smrs_pkg::DATA_W-1:0] wdata, input logic bval);
		smrs_reply_t                 r;
		logic [smrs_pkg::ADDR_W-1:0] reg_a;
		logic [smrs_pkg::BIT_W-1:0]  pos;
		logic [smrs_pkg::DATA_W-1:0] cur;
		int                          slot;
		bit                          in_win;
		r     = '0;
		pos   = a[smrs_pkg::BIT_W-1:0];
		reg_a = (op == smrs_pkg::OP_RD_BIT || op == smrs_pkg::OP_WR_BIT) ?
			(a >> smrs_pkg::BIT_W) + bit_offset : a;
		slot  = find_reg(reg_a, in_win);
		cur   = (slot < 0) ? '0 : (in_win ? win_mem[slot] : ovf_data[slot]);
		case (op)
			smrs_pkg::OP_RD_WORD: r.read_data = cur;
			smrs_pkg::OP_RD_BIT:  r.read_bit  = cur[pos];
			default: begin
				if (slot < 0 && ovf_used >= OVF_DEPTH) begin
					r.status = 1'b1;
				end else begin
					if (op == smrs_pkg::OP_WR_WORD)
						cur = wdata;
					else
						cur[pos] = bval;
					if (slot < 0) begin
						ovf_addr[ovf_used] = reg_a;
						ovf_data[ovf_used] = cur;
						ovf_used++;
					end else if (in_win) begin
						win_mem[slot] = cur;
					end else begin
						ovf_data[slot] = cur;
					end
				end
			end
		endcase
		pending_replies.push_back(r);
	endfunction

	function void check_reply(input logic [smrs_pkg::DATA_W-1:0] rd, input logic rb,
			input logic st);
		smrs_reply_t e;
		if (pending_replies.size() == 0) begin
			$display("%0t: reply with none outstanding: read_data %h read_bit %b status %b",
				$time, rd, rb, st);
			mismatches++;
			return;
		end
		e = pending_replies.pop_front();
		if (e.read_data !== rd) begin
			$display("%0t: read_data expected %h actual %h", $time, e.read_data, rd);
			mismatches++;
		end
		if (e.read_bit !== rb) begin
			$display("%0t: read_bit expected %b actual %b", $time, e.read_bit, rb);
			mismatches++;
		end
		if (e.status !== st) begin
			$display("%0t: status expected %b actual %b", $time, e.status, st);
			mismatches++;
		end
	endfunction
endclass

module tb_sparse_modbus_register_store_top;

	localparam int WINDOW_SIZE      = 256;
	localparam int OVERFLOW_ENTRIES = 64;
	// Longest legal quiet stretch is the clearing pass or the receiver hold-off plus one
	// full table scan; this is several times either.
	localparam int QUIET_LIMIT      = 8000;
	localparam int HOLD_CYCLES      = 300;
	localparam int HOLD_AT_REPLY    = 200;
	localparam int POOL_MAX         = 48;

	logic clk = 1'b0;
	logic arst_n;

	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [smrs_pkg::CFG_AW-1:0] paddr;
	logic [smrs_pkg::CFG_W-1:0]  pwdata;
	logic [smrs_pkg::CFG_W-1:0]  prdata;
	logic                        pready;

	smrs_req_if req_ch();
	smrs_rsp_if rsp_ch();

	reg_store_shadow #(WINDOW_SIZE, OVERFLOW_ENTRIES) sb;

	// calm: no idling on either side for a stretch of traffic
	bit                          calm = 1'b0;
	logic [smrs_pkg::ADDR_W-1:0] addr_pool [$];
	int                          quiet_cycles = 0;

	sparse_modbus_register_store_top #(
		.WINDOW_SIZE     (WINDOW_SIZE),
		.OVERFLOW_ENTRIES(OVERFLOW_ENTRIES)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #2 clk = ~clk;

	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < 28);
	endfunction

	// One access on the request channel. Valid only drops when the sender idles, so a
	// back-to-back item keeps valid high across the accepting edge.
	task automatic send_item(input smrs_pkg::op_t op, input logic [smrs_pkg::ADDR_W-1:0] a,
			input logic [smrs_pkg::DATA_W-1:0] wdata, input logic bval);
		if (roll_idle()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while (roll_idle()) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.addr       <= a;
		req_ch.write_data <= wdata;
		req_ch.bit_value  <= bval;
		// ready sampled here is the value seen at this edge, i.e. the handshake itself
		do @(posedge clk); while (!req_ch.ready);
		sb.apply_access(op, a, wdata, bval);
	endtask

	// Stop offering and wait until every reply is back; the block then holds nothing,
	// since every access yields exactly one reply.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	// APB write, then read back through the same select. Ends by deselecting so
	// that back-to-back calls never drive psel twice in one step.
	task automatic write_cfg(input logic [2:0] idx, input logic [smrs_pkg::CFG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_cfg(idx, val);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			$display("%0t: cfg reg %0d readback expected %h actual %h", $time, idx, val, prdata);
			sb.mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_layout(input logic [smrs_pkg::CFG_W-1:0] b0,
			input logic [smrs_pkg::CFG_W-1:0] b1, input logic [smrs_pkg::CFG_W-1:0] b2,
			input logic [smrs_pkg::CFG_W-1:0] b3, input logic [smrs_pkg::CFG_W-1:0] off);
		drain();
		write_cfg(smrs_pkg::REG_COIL_BASE, b0);
		write_cfg(smrs_pkg::REG_IN_COIL_BASE, b1);
		write_cfg(smrs_pkg::REG_IN_REG_BASE, b2);
		write_cfg(smrs_pkg::REG_HOLD_REG_BASE, b3);
		write_cfg(smrs_pkg::REG_BIT_OFFSET, off);
	endtask

	// Register address mix: window interiors and edges, recently used addresses
	// (so table entries get read back and rewritten), a small dense area that fills
	// the table, the address extremes, and fully random noise.
	function automatic logic [smrs_pkg::ADDR_W-1:0] pick_reg();
		int          sel;
		int          w;
		logic [31:0] base;
		sel  = $urandom_range(99);
		w    = $urandom_range(smrs_pkg::NUM_WIN-1);
		base = sb.win_base[w];
		if (sel < 35)
			return base + $urandom_range(WINDOW_SIZE-1);
		if (sel < 45) begin
			case ($urandom_range(3))
				0:       return base - 1;
				1:       return base;
				2:       return base + WINDOW_SIZE - 1;
				default: return base + WINDOW_SIZE;
			endcase
		end
		if (sel < 70 && addr_pool.size() > 0)
			return addr_pool[$urandom_range(addr_pool.size()-1)];
		if (sel < 85)
			return $urandom_range(3000);
		if (sel < 92)
			return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	task automatic run_random(input int n);
		smrs_pkg::op_t               op;
		logic [smrs_pkg::ADDR_W-1:0] target;
		logic [smrs_pkg::ADDR_W-1:0] a;
		logic [smrs_pkg::DATA_W-1:0] wdata;
		for (int k = 0; k < n; k++) begin
			op     = smrs_pkg::op_t'($urandom_range(3));
			target = pick_reg();
			addr_pool.push_back(target);
			if (addr_pool.size() > POOL_MAX) void'(addr_pool.pop_front());
			// bit ops: aim the bit address at the chosen register most of the time
			if ((op == smrs_pkg::OP_RD_BIT || op == smrs_pkg::OP_WR_BIT) &&
					$urandom_range(4) != 0)
				a = ((target - sb.bit_offset) << smrs_pkg::BIT_W) | 32'($urandom_range(15));
			else if (op == smrs_pkg::OP_RD_BIT || op == smrs_pkg::OP_WR_BIT)
				a = $urandom;
			else
				a = target;
			case ($urandom_range(5))
				0:       wdata = '0;
				1:       wdata = '1;
				default: wdata = smrs_pkg::DATA_W'($urandom);
			endcase
			send_item(op, a, wdata, 1'($urandom));
		end
	endtask

	// Reply side: checks each accepted reply, stalls at random, and once holds off
	// long enough for the block to back up into its request port.
	initial begin : reply_side
		int hold_left;
		int seen;
		hold_left    = 0;
		seen         = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_reply(rsp_ch.read_data, rsp_ch.read_bit, rsp_ch.status);
				seen++;
				if (seen == HOLD_AT_REPLY) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !roll_idle();
			end
		end
	end

	// Watchdog on handshakes of any kind.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		sb                = new();
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = smrs_pkg::OP_RD_WORD;
		req_ch.addr       = '0;
		req_ch.write_data = '0;
		req_ch.bit_value  = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset layout: windows tile 0..1023, no bit offset. The first item also waits
		// out the clearing pass through the handshake.
		send_item(smrs_pkg::OP_RD_WORD, 32'd0, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_WORD, 32'd0, 16'hFFFF, 1'b1);
		send_item(smrs_pkg::OP_RD_WORD, 32'd0, 16'h0000, 1'b0);
		// last register of the holding window, then the first address past it
		send_item(smrs_pkg::OP_WR_WORD, 32'd1023, 16'h8001, 1'b0);
		send_item(smrs_pkg::OP_RD_WORD, 32'd1023, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_WORD, 32'd1024, 16'h1234, 1'b0);
		send_item(smrs_pkg::OP_RD_WORD, 32'd1024, 16'h0000, 1'b0);
		// top address goes to the table, written with zero
		send_item(smrs_pkg::OP_WR_WORD, 32'hFFFF_FFFF, 16'h0000, 1'b1);
		send_item(smrs_pkg::OP_RD_WORD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		// absent register reads back as zero
		send_item(smrs_pkg::OP_RD_WORD, 32'h7654_3210, 16'h0000, 1'b0);
		// set then clear the top bit of register 5
		send_item(smrs_pkg::OP_WR_BIT, 32'd95, 16'h0000, 1'b1);
		send_item(smrs_pkg::OP_RD_BIT, 32'd95, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_BIT, 32'd95, 16'hFFFF, 1'b0);
		send_item(smrs_pkg::OP_RD_BIT, 32'd95, 16'h0000, 1'b1);
		// clearing a bit of an absent register still allocates a zero entry
		send_item(smrs_pkg::OP_WR_BIT, 32'd32003, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_RD_WORD, 32'd2000, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_RD_BIT, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_BIT, 32'd0, 16'h0000, 1'b1);

		// Overlapping windows: 0 and 1 share a base, 3 overlaps both, 2 ends at the
		// top of the address space. A bit offset of all ones makes the bit register
		// address wrap.
		set_layout(32'd100, 32'd100, 32'hFFFF_FF80, 32'd140, 32'hFFFF_FFFF);
		send_item(smrs_pkg::OP_WR_WORD, 32'd150, 16'hBEEF, 1'b0);
		send_item(smrs_pkg::OP_RD_WORD, 32'd120, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_WORD, 32'hFFFF_FFFF, 16'h5A5A, 1'b0);
		send_item(smrs_pkg::OP_RD_WORD, 32'h0000_007F, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_RD_BIT, 32'd0, 16'h0000, 1'b0);
		send_item(smrs_pkg::OP_WR_BIT, 32'h0000_001F, 16'h0000, 1'b0);
		run_random(140);

		// All windows stacked at zero; the receiver hold-off lands in this phase.
		set_layout(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		run_random(140);

		// All windows at the top address only; first part with no idling at all.
		set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		calm = 1'b1;
		run_random(80);
		calm = 1'b0;
		run_random(50);

		// Random layout near the dense area, one base anywhere.
		set_layout($urandom_range(4000), $urandom_range(4000), $urandom_range(4000), $urandom,
			$urandom_range(64));
		run_random(140);

		drain();
		// an access scans at most the whole table; leave room for a stray reply
		repeat (4 * (OVERFLOW_ENTRIES + 3)) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
